// ===== design/bes_pkg.sv =====
// ----------------------------------------------------------------------------
// bes_pkg: shared types for the cubic Bezier easing solver
// Input and result item structs, sequencer control between cells.
// ----------------------------------------------------------------------------
package bes_pkg;

	localparam int FRAC_BITS = 16;
	localparam int IN_W = 17;
	localparam int CFG_W = 6;

	typedef struct packed {
		logic [IN_W-1:0] target_x;
		logic [IN_W-1:0] ctrl1_x;
		logic [IN_W-1:0] ctrl1_y;
		logic [IN_W-1:0] ctrl2_x;
		logic [IN_W-1:0] ctrl2_y;
	} in_item_t;

	typedef struct packed {
		logic [IN_W-1:0] eased_y;
		logic            converged;
	} out_item_t;

	// operand selects of a multiply cell
	typedef enum logic [1:0] {
		OP_MUL_ADD = 2'd0,
		OP_MUL_ONLY = 2'd1
	} cell_op_t;

	typedef struct packed {
		logic     load;
		cell_op_t op;
	} cell_ctrl_t;

endpackage

// ===== design/bes_cell.sv =====
// ----------------------------------------------------------------------------
// bes_cell: one fixed-point multiply-accumulate cell
// Registers sat(sat(a*b >>> FRAC_BITS) + c) on load (c = 0 for OP_MUL_ONLY).
// ----------------------------------------------------------------------------
module bes_cell #(
	parameter int FRAC_BITS = 16
) (
	input  logic                      clk,
	input  bes_pkg::cell_ctrl_t       ctrl,
	input  logic signed [FRAC_BITS+7:0] a,
	input  logic signed [FRAC_BITS+7:0] b,
	input  logic signed [FRAC_BITS+7:0] c,
	output logic signed [FRAC_BITS+7:0] res_q
);
	import bes_pkg::*;

	localparam int W = FRAC_BITS + 8;
	localparam int PW = 2 * W;

	logic signed [PW-1:0] prod;
	logic signed [PW-FRAC_BITS-1:0] shp;
	logic signed [PW-FRAC_BITS:0] sum;
	logic signed [W-1:0] satp;
	logic signed [W-1:0] addend;

	function automatic logic signed [W-1:0] sat_w(input logic signed [PW-FRAC_BITS:0] v);
		logic signed [PW-FRAC_BITS:0] hi, lo;
		hi = (PW-FRAC_BITS+1)'((64'sd1 <<< (W-1)) - 1);
		lo = -(PW-FRAC_BITS+1)'(64'sd1 <<< (W-1));
		if (v > hi) return hi[W-1:0];
		if (v < lo) return lo[W-1:0];
		return v[W-1:0];
	endfunction

	// multiply, floor shift, saturate, then add and saturate again
	always_comb begin
		prod = a * b;
		shp = prod[PW-1:FRAC_BITS];
		satp = sat_w({shp[PW-FRAC_BITS-1], shp});
		addend = (ctrl.op == OP_MUL_ADD) ? c : '0;
		sum = (PW-FRAC_BITS+1)'(satp) + (PW-FRAC_BITS+1)'(addend);
	end

	// hold result for the neighbor
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			res_q <= sat_w(sum);
		end
	end

endmodule

// ===== design/bezier_easing_solver.sv =====
// ----------------------------------------------------------------------------
// bezier_easing_solver: cubic Bezier easing curve, y for given progress x
// Damped root search for t on a three-cell multiply chain, then y evaluation.
// ----------------------------------------------------------------------------
// Usage: pulse start with an item on in_item while busy is low. The item is
// taken at that edge and busy rises. The result appears on out_item as done
// is high for one cycle; the receiver cannot stall it. max_iterations is set
// through cfg_valid/cfg_ready/cfg_data (always ready); write only when idle.
// Diagonal control points go straight to the result, y = x. Otherwise the
// root search runs n passes (n <= max_iterations, 12 after reset; a pass
// that meets the tolerance counts) before the y evaluation. Each pass runs
// f through the chain of three multiply cells (Horner: k0*t+k1, *t+k2,
// *t-x), one cell in each of F1, F2, F3; UPD then stops or steps t. The y
// evaluation runs seven products on cell one in Y1 to Y7 and registers the
// sum in OUT. busy drops in the done cycle, so the next item can be taken
// there; one item is in flight at a time.
// Reset clears the sequencer and sets max_iterations to 12.
// ----------------------------------------------------------------------------
module bezier_easing_solver (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  bes_pkg::in_item_t    in_item,
	output logic                 done,
	output bes_pkg::out_item_t   out_item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [5:0]           cfg_data
);
	import bes_pkg::*;

	localparam int W = FRAC_BITS + 8;
	localparam logic signed [W-1:0] ONE = W'(64'sd1 <<< FRAC_BITS);
	localparam logic signed [W-1:0] SHI = W'((64'sd1 <<< (W-1)) - 1);
	localparam logic signed [W-1:0] SLO = W'(-(64'sd1 <<< (W-1)));
	localparam logic signed [W-1:0] EPS = W'(((64'sd5 <<< FRAC_BITS) + 5000) / 10000);
	localparam logic signed [W+1:0] K3 = (W+2)'(3);
	localparam logic signed [W+1:0] K6 = (W+2)'(6);

	typedef enum logic [3:0] {
		ST_IDLE, ST_F1, ST_F2, ST_F3, ST_UPD,
		ST_Y1, ST_Y2, ST_Y3, ST_Y4, ST_Y5, ST_Y6, ST_Y7, ST_OUT
	} state_t;

	state_t st_q;
	logic [CFG_W-1:0] max_it_q, it_q;
	logic signed [W-1:0] x_q, ay_q, by_q, k0_q, k1_q, k2_q, t_q;
	logic signed [W-1:0] t2_q, t3_q, r2_q;
	logic signed [W+1:0] tb_q;
	logic conv_q;
	logic [IN_W-1:0] y_q;
	logic fin_q;
	logic [IN_W-1:0] y_fin;

	cell_ctrl_t c0, c1, c2;
	logic signed [W-1:0] a0, b0, cc0, a1, b1, cc1, a2, b2, cc2;
	logic signed [W-1:0] p0, p1, p2;

	function automatic logic signed [W-1:0] clamp_in(input logic [IN_W-1:0] v);
		logic [W-1:0] e;
		e = W'(v);
		return (e > ONE) ? ONE : e;
	endfunction

	function automatic logic signed [W-1:0] sat2(input logic signed [W+1:0] v);
		if (v > (W+2)'(SHI)) return SHI;
		if (v < (W+2)'(SLO)) return SLO;
		return v[W-1:0];
	endfunction

	logic signed [W-1:0] ix, iax, iay, ibx, iby;
	always_comb begin
		ix = clamp_in(in_item.target_x);
		iax = clamp_in(in_item.ctrl1_x);
		iay = clamp_in(in_item.ctrl1_y);
		ibx = clamp_in(in_item.ctrl2_x);
		iby = clamp_in(in_item.ctrl2_y);
	end

	// chain of cells: cell n+1 takes cell n's output
	bes_cell #(.FRAC_BITS(FRAC_BITS)) u_c0 (.clk, .ctrl(c0), .a(a0), .b(b0), .c(cc0), .res_q(p0));
	bes_cell #(.FRAC_BITS(FRAC_BITS)) u_c1 (.clk, .ctrl(c1), .a(a1), .b(b1), .c(cc1), .res_q(p1));
	bes_cell #(.FRAC_BITS(FRAC_BITS)) u_c2 (.clk, .ctrl(c2), .a(a2), .b(b2), .c(cc2), .res_q(p2));

	logic signed [W-1:0] r_now, fh;
	logic signed [W+3:0] ysum;
	logic f_ok;
	always_comb begin
		r_now = sat2((W+2)'(ONE) - (W+2)'(t_q));
		fh = p2 >>> 1;
		f_ok = (p2 <= EPS) && (p2 >= -EPS);
		ysum = (W+4)'(t3_q) + (W+4)'(tb_q) + (W+4)'(K3) * (W+4)'(p0);
		// defaults
		c0 = '{load: 1'b0, op: OP_MUL_ADD};
		c1 = '{load: 1'b0, op: OP_MUL_ADD};
		c2 = '{load: 1'b0, op: OP_MUL_ADD};
		a0 = k0_q; b0 = t_q; cc0 = k1_q;
		a1 = p0; b1 = t_q; cc1 = k2_q;
		a2 = p1; b2 = t_q; cc2 = -x_q;
		unique case (st_q)
			ST_F1: c0.load = 1'b1;
			ST_F2: c1.load = 1'b1;
			ST_F3: c2.load = 1'b1;
			// y: t2, t3, r2, t2*r, *by, t*r2, *ay
			ST_Y1: begin c0 = '{load: 1'b1, op: OP_MUL_ONLY}; a0 = t_q; end
			ST_Y2: begin c0 = '{load: 1'b1, op: OP_MUL_ONLY}; a0 = p0; end
			ST_Y3: begin c0 = '{load: 1'b1, op: OP_MUL_ONLY}; a0 = r_now; b0 = r_now; end
			ST_Y4: begin c0 = '{load: 1'b1, op: OP_MUL_ONLY}; a0 = t2_q; b0 = r_now; end
			ST_Y5: begin c0 = '{load: 1'b1, op: OP_MUL_ONLY}; a0 = p0; b0 = by_q; end
			ST_Y6: begin c0 = '{load: 1'b1, op: OP_MUL_ONLY}; a0 = t_q; b0 = r2_q; end
			ST_Y7: begin c0 = '{load: 1'b1, op: OP_MUL_ONLY}; a0 = p0; b0 = ay_q; end
			default: ;
		endcase
		c2.op = OP_MUL_ADD;
	end

	// saturate the final sum to [0, 1]
	always_comb begin
		if (ysum < 0) y_fin = '0;
		else if (ysum > (W+4)'(ONE)) y_fin = ONE[IN_W-1:0];
		else y_fin = ysum[IN_W-1:0];
	end

	// sequencer and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			max_it_q <= CFG_W'(12);
			done <= 1'b0;
			x_q <= '0; ay_q <= '0; by_q <= '0;
			k0_q <= '0; k1_q <= '0; k2_q <= '0; t_q <= '0;
			t2_q <= '0; t3_q <= '0; r2_q <= '0; tb_q <= '0;
			it_q <= '0; conv_q <= 1'b0; y_q <= '0; fin_q <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_valid && cfg_ready) max_it_q <= cfg_data;
			unique case (st_q)
				ST_IDLE: if (start) begin
					x_q <= ix; ay_q <= iay; by_q <= iby;
					k0_q <= sat2((W+2)'(ONE) + K3 * (W+2)'(iax) - K3 * (W+2)'(ibx));
					k1_q <= sat2(K3 * (W+2)'(ibx) - K6 * (W+2)'(iax));
					k2_q <= sat2(K3 * (W+2)'(iax));
					t_q <= ix; it_q <= '0; conv_q <= 1'b0;
					if (iax == iay && ibx == iby) begin
						y_q <= ix[IN_W-1:0]; conv_q <= 1'b1; st_q <= ST_OUT;
					end else begin
						st_q <= (max_it_q == '0) ? ST_Y1 : ST_F1;
					end
				end
				ST_F1: st_q <= ST_F2;
				ST_F2: st_q <= ST_F3;
				ST_F3: st_q <= ST_UPD;
				ST_UPD: begin
					if (f_ok) begin
						conv_q <= 1'b1; st_q <= ST_Y1;
					end else begin
						t_q <= sat2((W+2)'(t_q) - (W+2)'(fh));
						it_q <= it_q + 1'b1;
						st_q <= (it_q + 1'b1 == max_it_q) ? ST_Y1 : ST_F1;
					end
				end
				ST_Y1: st_q <= ST_Y2;
				ST_Y2: begin t2_q <= p0; st_q <= ST_Y3; end
				ST_Y3: begin t3_q <= p0; st_q <= ST_Y4; end
				ST_Y4: begin r2_q <= p0; st_q <= ST_Y5; end
				ST_Y5: st_q <= ST_Y6;
				ST_Y6: begin tb_q <= K3 * (W+2)'(p0); st_q <= ST_Y7; end
				ST_Y7: st_q <= ST_OUT;
				ST_OUT: begin
					done <= 1'b1;
					if (fin_q) y_q <= y_fin;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
			// final sum lands once ay product is ready (cell output in ST_OUT)
			if (st_q == ST_Y7) fin_q <= 1'b1;
			else fin_q <= 1'b0;
		end
	end

	assign busy = (st_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_item.eased_y = y_q;
	assign out_item.converged = conv_q;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done held");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("done while busy");
	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_F1) |-> (it_q < max_it_q)) else $error("iteration overrun");

endmodule

// ===== verif/tb_bezier_easing_solver.sv =====
// ----------------------------------------------------------------------------
// tb_bezier_easing_solver: self-checking bench for the Bezier easing solver
// Drives items through start/busy, predicts eased_y and converged in fixed
// point, and checks every done strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_bezier_easing_solver;
	import bes_pkg::*;

	localparam int FB = 16;
	localparam longint ONE = 64'sd1 << FB;
	localparam longint SAT_HI = (64'sd1 << (FB + 7)) - 1;
	localparam longint SAT_LO = -(64'sd1 << (FB + 7));
	localparam longint EPS = ((64'sd5 << FB) + 5000) / 10000;
	localparam int N_RANDOM = 1300;

	typedef struct {
		in_item_t item;
		bit       has_gold;
		out_item_t gold;
	} vec_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	in_item_t   in_item = '0;
	logic       done;
	out_item_t  out_item;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [5:0] cfg_data = '0;

	logic [5:0] iter_limit;
	out_item_t  pending_y[$];
	int         fail_count = 0;

	bezier_easing_solver u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_item(in_item),
		.done(done), .out_item(out_item), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	function automatic longint clip(longint v);
		if (v > SAT_HI) return SAT_HI;
		if (v < SAT_LO) return SAT_LO;
		return v;
	endfunction

	// product in Q.16, floor rounding (>>> floors on signed)
	function automatic longint qmul(longint a, longint b);
		return clip((a * b) >>> FB);
	endfunction

	function automatic longint clamp_one(logic [16:0] v);
		return (longint'(v) > ONE) ? ONE : longint'(v);
	endfunction

	function automatic out_item_t ease(in_item_t it, logic [5:0] lim);
		longint x, ax, ay, bx, by, k0, k1, k2, t, f, t2, t3, r, r2, y;
		out_item_t o;
		x = clamp_one(it.target_x);
		ax = clamp_one(it.ctrl1_x);
		ay = clamp_one(it.ctrl1_y);
		bx = clamp_one(it.ctrl2_x);
		by = clamp_one(it.ctrl2_y);
		o.converged = 1'b0;
		if (ax == ay && bx == by) begin
			o.eased_y = x[16:0];
			o.converged = 1'b1;
			return o;
		end
		k0 = clip(ONE + 3 * ax - 3 * bx);
		k1 = clip(3 * bx - 6 * ax);
		k2 = clip(3 * ax);
		t = x;
		for (int i = 0; i < lim; i++) begin
			f = clip(qmul(k0, t) + k1);
			f = clip(qmul(f, t) + k2);
			f = clip(qmul(f, t) - x);
			if (f <= EPS && f >= -EPS) begin
				o.converged = 1'b1;
				break;
			end
			t = clip(t - (f >>> 1));
		end
		t2 = qmul(t, t);
		t3 = qmul(t2, t);
		r = clip(ONE - t);
		r2 = qmul(r, r);
		y = t3 + 3 * qmul(qmul(t2, r), by) + 3 * qmul(qmul(t, r2), ay);
		if (y < 0) y = 0;
		if (y > ONE) y = ONE;
		o.eased_y = y[16:0];
		return o;
	endfunction

	function automatic logic [16:0] pick_coord();
		case ($urandom_range(0, 9))
			0: return 17'd0;
			1: return 17'(ONE);
			2: return 17'($urandom_range(65537, 131071));
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	// check each result against the oldest prediction
	always @(posedge clk) begin
		out_item_t exp_y;
		if (arst_n && done) begin
			if (pending_y.size() == 0) begin
				$error("unexpected result eased_y=%0d", out_item.eased_y);
				fail_count++;
			end else begin
				exp_y = pending_y.pop_front();
				if (out_item.eased_y !== exp_y.eased_y) begin
					$error("eased_y expected %0d actual %0d", exp_y.eased_y, out_item.eased_y);
					fail_count++;
				end
				if (out_item.converged !== exp_y.converged) begin
					$error("converged expected %0d actual %0d", exp_y.converged,
						out_item.converged);
					fail_count++;
				end
			end
		end
	end

	task automatic wait_idle();
		while (pending_y.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_limit(logic [5:0] v);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		iter_limit = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// offer one item, hold until accepted, then drop start
	task automatic send_item(in_item_t it, bit has_gold, out_item_t gold);
		out_item_t p;
		in_item = it;
		start = 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		p = ease(it, iter_limit);
		if (has_gold && p !== gold) begin
			$error("table row disagrees: eased_y expected %0d predicted %0d",
				gold.eased_y, p.eased_y);
			fail_count++;
		end
		pending_y.push_back(p);
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic idle_gap();
		int n;
		n = $urandom_range(0, 19);
		if (n < 12) n = 0;
		else if (n < 18) n = $urandom_range(1, 4);
		else n = $urandom_range(10, 60);
		repeat (n) @(negedge clk);
	endtask

	initial begin
		vec_t      dir_tab[$];
		vec_t      v;
		in_item_t  it;
		logic [5:0] limits[$];
		iter_limit = 6'd12;
		// diagonal and clamped rows have results readable at a glance
		v.has_gold = 1; v.item = '{0, 0, 0, 0, 0}; v.gold = '{0, 1}; dir_tab.push_back(v);
		v.item = '{65536, 65536, 65536, 65536, 65536}; v.gold = '{65536, 1};
		dir_tab.push_back(v);
		v.item = '{131071, 131071, 131071, 0, 0}; v.gold = '{65536, 1}; dir_tab.push_back(v);
		v.item = '{32768, 70000, 65536, 1000, 1000}; v.gold = '{32768, 1};
		dir_tab.push_back(v);
		v.has_gold = 0; v.gold = '{0, 0};
		v.item = '{32768, 27525, 0, 38011, 65536}; dir_tab.push_back(v);
		v.item = '{0, 65536, 0, 0, 65536}; dir_tab.push_back(v);
		v.item = '{65536, 0, 65536, 65536, 0}; dir_tab.push_back(v);
		v.item = '{131071, 131071, 0, 0, 131071}; dir_tab.push_back(v);
		v.item = '{43690, 65536, 0, 65536, 0}; dir_tab.push_back(v);
		v.item = '{21845, 0, 65536, 0, 65536}; dir_tab.push_back(v);
		v.item = '{87381, 43690, 21845, 21845, 43690}; dir_tab.push_back(v);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_tab[i]) send_item(dir_tab[i].item, dir_tab[i].has_gold, dir_tab[i].gold);
		// zero iteration limit leaves t at x
		set_limit(6'd0);
		for (int i = 4; i < dir_tab.size(); i++) send_item(dir_tab[i].item, 0, '0);
		set_limit(6'd63);
		for (int i = 4; i < dir_tab.size(); i++) send_item(dir_tab[i].item, 0, '0);

		limits = '{6'd1, 6'd63, 6'd12, 6'd0, 6'd5, 6'd42, 6'd12, 6'd21};
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 160 == 0) set_limit(limits[(i / 160) % limits.size()]);
			if (i % 97 == 50) wait_idle();
			it.target_x = pick_coord();
			it.ctrl1_x = pick_coord();
			it.ctrl1_y = ($urandom_range(0, 15) == 0) ? it.ctrl1_x : pick_coord();
			it.ctrl2_x = pick_coord();
			it.ctrl2_y = ($urandom_range(0, 15) == 0) ? it.ctrl2_x : pick_coord();
			send_item(it, 0, '0);
			idle_gap();
		end
		wait_idle();
		repeat (140) @(negedge clk);
		if (fail_count == 0 && pending_y.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#(20 * 3000000);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
